FILE: rtl/s2l_pkg.sv
// Shared constants, types and the elaboration-time helper of the sRGB to CIELAB converter.
// No dependencies.
package s2l_pkg;

   typedef logic [16:0] q116_type;

   localparam longint unsigned ONE30 = 64'd1 << 30;

   // sRGB to XYZ matrix in Q0.16, X and Z rows already divided by the D65 white
   localparam logic [15:0] COEF [0:2][0:2] = '{
      '{16'd28439, 16'd24655, 16'd12441},
      '{16'd13938, 16'd46868, 16'd4730},
      '{16'd1164,  16'd7174,  16'd57198}
   };

   // Lab function knee: above this T the cube-root branch applies
   localparam q116_type LAB_KNEE = 17'd580;
   // linear branch: (24389*T + 28311552 + 1566) / 3132
   localparam logic [14:0] LIN_SLOPE = 15'd24389;
   localparam logic [25:0] LIN_OFFSET = 26'd28313118;
   localparam int unsigned LIN_SHIFT = 38;
   localparam logic [26:0] LIN_RECIP = 27'(((64'd1 << LIN_SHIFT) + 64'd3131) / 64'd3132);

   localparam int unsigned CBRT_STEPS = 18;
   localparam int unsigned LAB_LATENCY = CBRT_STEPS + 2;

   // Largest Q0.30 r with r^5 <= s, powers truncated after every multiply.
   function automatic longint unsigned root5_q30(input longint unsigned s);
      longint unsigned lo, hi, mid, r2, r4, p5;
      lo = 0;
      hi = ONE30;
      for (int k = 0; k < 32; k++) begin
         if (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            r2 = (mid * mid) >> 30;
            r4 = (r2 * r2) >> 30;
            p5 = (r4 * mid) >> 30;
            if (p5 <= s) lo = mid;
            else hi = mid - 64'd1;
         end
      end
      return lo;
   endfunction

endpackage

FILE: rtl/s2l_lab_curve.sv
// Pipelined CIELAB companding function f(T) for one channel, Q1.16 in and out.
// Depends on s2l_pkg.
module s2l_lab_curve (
   input  logic               clock,
   input  s2l_pkg::q116_type  t_in,
   output s2l_pkg::q116_type  f_out
);

   localparam int unsigned STEPS = s2l_pkg::CBRT_STEPS;

   // radicand T * 2^35; bit-serial integer cube root, one result bit per stage
   logic [53:0] x_ff    [0:STEPS];
   logic [18:0] y_ff    [0:STEPS];
   logic [37:0] ysq_ff  [0:STEPS];
   logic        cube_ff [0:STEPS];
   logic [25:0] lin_n_ff;
   logic [52:0] lin_prod_ff;
   logic [16:0] lin_q_ff [2:STEPS];
   s2l_pkg::q116_type f_ff;

   always_ff @(posedge clock) begin
      x_ff[0]    <= 54'(t_in) << 35;
      y_ff[0]    <= '0;
      ysq_ff[0]  <= '0;
      cube_ff[0] <= (t_in > s2l_pkg::LAB_KNEE);
      lin_n_ff   <= 26'(t_in[9:0] * s2l_pkg::LIN_SLOPE) + s2l_pkg::LIN_OFFSET;
   end

   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      localparam int unsigned SH = 3 * (STEPS - k);
      logic [18:0] y2;
      logic [37:0] ysq2;
      logic [55:0] trial;
      always_comb begin
         y2    = y_ff[k-1] << 1;
         ysq2  = ysq_ff[k-1] << 2;
         trial = (56'(ysq2) * 56'd3 + 56'(y2) * 56'd3 + 56'd1) << SH;
      end
      always_ff @(posedge clock) begin
         cube_ff[k] <= cube_ff[k-1];
         if (56'(x_ff[k-1]) >= trial) begin
            x_ff[k]   <= x_ff[k-1] - 54'(trial);
            y_ff[k]   <= y2 + 19'd1;
            ysq_ff[k] <= ysq2 + 38'(y2) * 38'd2 + 38'd1;
         end else begin
            x_ff[k]   <= x_ff[k-1];
            y_ff[k]   <= y2;
            ysq_ff[k] <= ysq2;
         end
      end
   end

   // linear branch: multiply by reciprocal, then shift
   always_ff @(posedge clock) begin
      lin_prod_ff <= 53'(lin_n_ff) * 53'(s2l_pkg::LIN_RECIP);
      lin_q_ff[2] <= 17'(lin_prod_ff >> s2l_pkg::LIN_SHIFT);
   end

   for (genvar k = 3; k <= STEPS; k++) begin : g_lin_delay
      always_ff @(posedge clock) lin_q_ff[k] <= lin_q_ff[k-1];
   end

   // largest mid with (2*mid-1)^3 <= radicand is (cbrt+1)/2
   always_ff @(posedge clock) begin
      if (cube_ff[STEPS]) f_ff <= 17'((y_ff[STEPS] + 19'd1) >> 1);
      else f_ff <= lin_q_ff[STEPS];
   end

   assign f_out = f_ff;

endmodule

FILE: rtl/srgb_to_cielab_converter.sv
// Top level of the sRGB to CIELAB (D65) converter: pixel pipeline, tables, output rounding.
// Depends on s2l_pkg and s2l_lab_curve.
//
// Converts one sRGB pixel per clock into CIELAB L*, a*, b* with OUT_FRAC_BITS
// fractional bits. A request is taken on every clock where start is high; busy
// is always low, since the pipeline never holds. Each pixel's result shows on
// the rsp_ ports for one cycle, marked by rsp_valid, after its request passes
// the linearization table, matrix products and sums, the cube-root unit (one
// result bit per stage), and scaling, rounding and saturation. Results leave in
// request order; the receiver cannot stall them. No state survives a pixel.
module srgb_to_cielab_converter #(
   parameter int CHANNEL_BITS  = 8,
   parameter int OUT_FRAC_BITS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [CHANNEL_BITS-1:0]   req_red,
   input  logic [CHANNEL_BITS-1:0]   req_green,
   input  logic [CHANNEL_BITS-1:0]   req_blue,
   output logic                      rsp_valid,
   output logic [14:0]               rsp_lightness,
   output logic signed [15:0]        rsp_green_red_axis,
   output logic signed [15:0]        rsp_blue_yellow_axis
);

   localparam int unsigned ENTRIES = 1 << CHANNEL_BITS;
   localparam longint unsigned CODE_MAX = longint'(ENTRIES) - 64'd1;
   localparam int unsigned DEPTH = 3 + s2l_pkg::LAB_LATENCY + 2;
   localparam int unsigned SH = 16 - OUT_FRAC_BITS;
   localparam logic signed [27:0] HALF = 28'sd1 <<< (SH - 1);
   localparam logic signed [27:0] L_MAX = 28'sd100 <<< OUT_FRAC_BITS;
   localparam logic signed [27:0] AB_LIM = 28'sd128 <<< OUT_FRAC_BITS;

   // Linearization table, filled at elaboration with the sRGB transfer curve
   s2l_pkg::q116_type lin_rom [ENTRIES];

   for (genvar gi = 0; gi < ENTRIES; gi++) begin : g_lin
      localparam longint unsigned C  = longint'(gi);
      localparam longint unsigned TQ = ((64'd1000 * C + 64'd55 * CODE_MAX) << 30)
                                       / (64'd1055 * CODE_MAX);
      localparam longint unsigned SQ = (TQ * TQ) >> 30;
      localparam longint unsigned PQ = (SQ * s2l_pkg::root5_q30(SQ)) >> 30;
      localparam longint unsigned CURVE = (PQ + 64'd8192) >> 14;
      localparam longint unsigned LINEAR = (C * 64'd6553600 + 64'd646 * CODE_MAX)
                                           / (64'd1292 * CODE_MAX);
      localparam longint unsigned VAL = (C * 64'd100000 > 64'd4045 * CODE_MAX) ?
                                        CURVE : LINEAR;
      assign lin_rom[gi] = 17'(VAL);
   end

   logic [DEPTH-1:0] valid_ff;
   s2l_pkg::q116_type lin_ff [3];
   logic [32:0] prod_ff [3][3];
   s2l_pkg::q116_type tri_ff [3];
   s2l_pkg::q116_type f_val [3];
   logic signed [27:0] l_raw_ff, a_raw_ff, b_raw_ff;
   logic [14:0] lightness_ff;
   logic signed [15:0] gr_ff, by_ff;

   // the pipeline never stalls
   assign busy = 1'b0;

   // Advance the valid bit alongside the data; only control state is reset
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else valid_ff <= {valid_ff[DEPTH-2:0], start};
   end

   // Stage 1: look up linear intensities
   always_ff @(posedge clock) begin
      lin_ff[0] <= lin_rom[req_red];
      lin_ff[1] <= lin_rom[req_green];
      lin_ff[2] <= lin_rom[req_blue];
   end

   // Stage 2: matrix products; stage 3: row sums rounded to Q1.16
   for (genvar r = 0; r < 3; r++) begin : g_row
      logic [33:0] acc;
      for (genvar c = 0; c < 3; c++) begin : g_col
         always_ff @(posedge clock)
            prod_ff[r][c] <= 33'(s2l_pkg::COEF[r][c]) * 33'(lin_ff[c]);
      end
      assign acc = 34'(prod_ff[r][0]) + 34'(prod_ff[r][1]) + 34'(prod_ff[r][2])
                   + 34'd32768;
      always_ff @(posedge clock) tri_ff[r] <= acc[32:16];

      s2l_lab_curve u_lab (
         .clock (clock),
         .t_in  (tri_ff[r]),
         .f_out (f_val[r])
      );
   end

   // Scale into L, a, b before rounding
   always_ff @(posedge clock) begin
      l_raw_ff <= 28'(f_val[1]) * 28'sd116 - 28'sd1048576;
      a_raw_ff <= (28'(f_val[0]) - 28'(f_val[1])) * 28'sd500;
      b_raw_ff <= (28'(f_val[1]) - 28'(f_val[2])) * 28'sd200;
   end

   // Round to nearest with ties away from zero
   function automatic logic signed [27:0] round_sym(input logic signed [27:0] v);
      logic signed [27:0] mag, q;
      mag = (v < 0) ? -v : v;
      q = (mag + HALF) >>> SH;
      return (v < 0) ? -q : q;
   endfunction

   logic signed [27:0] l_rnd, a_rnd, b_rnd, l_clip, a_sat, b_sat;

   always_comb begin
      l_rnd = round_sym(l_raw_ff);
      a_rnd = round_sym(a_raw_ff);
      b_rnd = round_sym(b_raw_ff);
      l_clip = (l_rnd < 0) ? 28'sd0 : ((l_rnd > L_MAX) ? L_MAX : l_rnd);
      a_sat = (a_rnd > AB_LIM - 28'sd1) ? AB_LIM - 28'sd1 :
              ((a_rnd < -AB_LIM) ? -AB_LIM : a_rnd);
      b_sat = (b_rnd > AB_LIM - 28'sd1) ? AB_LIM - 28'sd1 :
              ((b_rnd < -AB_LIM) ? -AB_LIM : b_rnd);
   end

   // Hold results in output registers; fields keep their low bits
   always_ff @(posedge clock) begin
      lightness_ff <= l_clip[14:0];
      gr_ff        <= a_sat[15:0];
      by_ff        <= b_sat[15:0];
   end

   assign rsp_valid            = valid_ff[DEPTH-1];
   assign rsp_lightness        = lightness_ff;
   assign rsp_green_red_axis   = gr_ff;
   assign rsp_blue_yellow_axis = by_ff;

endmodule
